/* src/stable_priority_table_unit_assert.svh */
// Assertion macros shared by the RTL; clk and rst_n come from the using scope.
`ifndef STABLE_PRIORITY_TABLE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define SPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define SPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/spt_pkg.sv */
package spt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 16;
  localparam int AGE_W     = 7;
  localparam int LVL_W     = 4;
  localparam int POS_W     = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CHANGE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_PLACE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DROP,
    CELL_PLACE
  } cell_op_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic [LVL_W-1:0] level;
  } slot_t;

  typedef struct packed {
    cell_op_t op;
    slot_t    ins;
  } cell_ctl_t;

  // ripple between neighbors: key match seen at or before, level >= new level
  typedef struct packed {
    logic seen;
    logic ge;
  } chain_t;

  typedef struct packed {
    logic first;
    logic place;
  } cell_stat_t;

endpackage

/* src/spt_if.sv */
interface spt_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [spt_pkg::KEY_W-1:0] cust_key;
  logic [spt_pkg::AGE_W-1:0] cust_age;
  logic [spt_pkg::LVL_W-1:0] prio_level;

  modport source (output valid, req_type, cust_key, cust_age, prio_level, input ready);
  modport sink (input valid, req_type, cust_key, cust_age, prio_level, output ready);
endinterface

interface spt_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [spt_pkg::AGE_W-1:0] found_age;
  logic [spt_pkg::LVL_W-1:0] found_level;
  logic [spt_pkg::POS_W-1:0] found_pos;
  logic [spt_pkg::POS_W-1:0] entry_count;

  modport source (output valid, status, found_age, found_level, found_pos, entry_count,
                  input ready);
  modport sink (input valid, status, found_age, found_level, found_pos, entry_count,
                output ready);
endinterface

/* src/stable_priority_table_unit.sv */
// Stable priority table: up to DEPTH entries (key, age, level) kept in
// descending level order, arrival order within a level.
// in_ch: request transfer (insert, remove, search, change priority).
// out_ch: exactly one result transfer per request (status, matched age,
// level, 1-based position, entry count after the request).
// Sequencing: a request passes through accept (IDLE), the drop/match
// pass (DROP) and the place pass (PLACE); the result is registered into
// the output register at the end of the place pass, and no new request
// is accepted until the FSM is back in IDLE. The two passes over the
// cell chain are a match/remove shift and then an ordered insert shift.
// Each cell compares its entry against the request at once; first-match
// and insert point ripple cell to cell.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; entry contents are not cleared.
// When out_ch stalls the result stays in the output register; a following
// request finishes its match pass and then waits, without touching the
// table, until the output register is free.
module stable_priority_table_unit #(
  parameter int DEPTH = spt_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  spt_in_if.sink   in_ch,
  spt_out_if.source out_ch
);

  `include "stable_priority_table_unit_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = spt_pkg::POS_W;

  spt_pkg::state_t state_r, state_nxt;
  spt_pkg::req_t   req_r;
  logic [spt_pkg::KEY_W-1:0] key_r;
  logic [spt_pkg::AGE_W-1:0] age_r;
  logic [spt_pkg::LVL_W-1:0] lvl_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic                      fnd_r;
  logic                      empty_r;
  logic [spt_pkg::AGE_W-1:0] fnd_age_r;
  logic [spt_pkg::LVL_W-1:0] fnd_lvl_r;
  logic [PW-1:0]             fnd_pos_r;

  logic                      out_valid_r;
  spt_pkg::status_t          out_sts_r;
  logic [spt_pkg::AGE_W-1:0] out_age_r;
  logic [spt_pkg::LVL_W-1:0] out_lvl_r;
  logic [PW-1:0]             out_pos_r;
  logic [PW-1:0]             out_cnt_r;

  spt_pkg::cell_ctl_t  ctl;
  spt_pkg::slot_t      slots [DEPTH];
  spt_pkg::chain_t     chains [DEPTH+1];
  spt_pkg::cell_stat_t stats [DEPTH];

  logic                      in_rdy;
  logic                      out_free;
  logic                      load_out;
  logic                      found;
  logic [spt_pkg::AGE_W-1:0] hit_age;
  logic [spt_pkg::LVL_W-1:0] hit_lvl;
  logic [PW-1:0]             hit_pos;
  logic [PW-1:0]             ins_pos;

  spt_pkg::status_t          res_sts;
  logic [spt_pkg::AGE_W-1:0] res_age;
  logic [spt_pkg::LVL_W-1:0] res_lvl;
  logic [PW-1:0]             res_pos;
  logic [CW+PW-1:0]          cnt_ext;

  assign chains[0].seen = 1'b0;
  assign chains[0].ge   = 1'b1;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spt_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cnt        (cnt_r),
      .left_slot  ((g == 0) ? ctl.ins : slots[(g == 0) ? 0 : g - 1]),
      .right_slot (slots[(g == DEPTH - 1) ? g : g + 1]),
      .chain_in   (chains[g]),
      .chain_out  (chains[g+1]),
      .slot       (slots[g]),
      .stat       (stats[g])
    );
  end

  assign found = chains[DEPTH].seen;

  always_comb begin
    hit_age = '0;
    hit_lvl = '0;
    hit_pos = '0;
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stats[i].first) begin
        hit_age = hit_age | slots[i].age;
        hit_lvl = hit_lvl | slots[i].level;
        hit_pos = hit_pos | PW'(i + 1);
      end
      if (stats[i].place) begin
        ins_pos = ins_pos | PW'(i + 1);
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = spt_pkg::ST_DROP;
        end
      end
      spt_pkg::ST_DROP: begin
        state_nxt = spt_pkg::ST_PLACE;
      end
      spt_pkg::ST_PLACE: begin
        if (out_free) begin
          state_nxt = spt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_rdy        = 1'b0;
    load_out      = 1'b0;
    cnt_nxt       = cnt_r;
    ctl.op        = spt_pkg::CELL_HOLD;
    ctl.ins.key   = key_r;
    ctl.ins.age   = (req_r == spt_pkg::REQ_CHANGE) ? fnd_age_r : age_r;
    ctl.ins.level = lvl_r;
    res_sts       = spt_pkg::STS_NOT_FOUND;
    res_age       = '0;
    res_lvl       = '0;
    res_pos       = '0;
    case (state_r)
      spt_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
      end
      spt_pkg::ST_DROP: begin
        if ((req_r == spt_pkg::REQ_REMOVE || req_r == spt_pkg::REQ_CHANGE) && found) begin
          ctl.op  = spt_pkg::CELL_DROP;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      spt_pkg::ST_PLACE: begin
        if (out_free) begin
          load_out = 1'b1;
          case (req_r)
            spt_pkg::REQ_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                res_sts = spt_pkg::STS_FULL;
              end else begin
                ctl.op  = spt_pkg::CELL_PLACE;
                cnt_nxt = cnt_r + CW'(1);
                res_sts = spt_pkg::STS_DONE;
                res_age = age_r;
                res_lvl = lvl_r;
                res_pos = ins_pos;
              end
            end
            spt_pkg::REQ_REMOVE: begin
              if (empty_r) begin
                res_sts = spt_pkg::STS_EMPTY;
              end else if (fnd_r) begin
                res_sts = spt_pkg::STS_DONE;
                res_age = fnd_age_r;
                res_lvl = fnd_lvl_r;
                res_pos = fnd_pos_r;
              end
            end
            spt_pkg::REQ_SEARCH: begin
              if (fnd_r) begin
                res_sts = spt_pkg::STS_DONE;
                res_age = fnd_age_r;
                res_lvl = fnd_lvl_r;
                res_pos = fnd_pos_r;
              end
            end
            spt_pkg::REQ_CHANGE: begin
              if (fnd_r) begin
                ctl.op  = spt_pkg::CELL_PLACE;
                cnt_nxt = cnt_r + CW'(1);
                res_sts = spt_pkg::STS_DONE;
                res_age = fnd_age_r;
                res_lvl = lvl_r;
                res_pos = ins_pos;
              end
            end
            default: begin
              res_sts = spt_pkg::STS_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  assign cnt_ext = {{PW{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      req_r <= spt_pkg::req_t'(in_ch.req_type);
      key_r <= in_ch.cust_key;
      age_r <= in_ch.cust_age;
      lvl_r <= in_ch.prio_level;
    end
    if (state_r == spt_pkg::ST_DROP) begin
      fnd_r     <= found;
      empty_r   <= (cnt_r == '0);
      fnd_age_r <= hit_age;
      fnd_lvl_r <= hit_lvl;
      fnd_pos_r <= hit_pos;
    end
    if (load_out) begin
      out_sts_r <= res_sts;
      out_age_r <= res_age;
      out_lvl_r <= res_lvl;
      out_pos_r <= res_pos;
      out_cnt_r <= cnt_ext[PW-1:0];
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_sts_r;
  assign out_ch.found_age   = out_age_r;
  assign out_ch.found_level = out_lvl_r;
  assign out_ch.found_pos   = out_pos_r;
  assign out_ch.entry_count = out_cnt_r;

  `SPT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH))
  `SPT_ASSERT_NXT(a_accept_to_drop, in_rdy && in_ch.valid, state_r == spt_pkg::ST_DROP)
  `SPT_ASSERT_NXT(a_result_loaded, state_r == spt_pkg::ST_PLACE && out_free, out_valid_r)
  `SPT_ASSERT_NXT(a_idle_cnt_hold, state_r == spt_pkg::ST_IDLE, $stable(cnt_r))

endmodule

/* src/spt_cell.sv */
module spt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic               clk,
  input  spt_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      cnt,
  input  spt_pkg::slot_t     left_slot,
  input  spt_pkg::slot_t     right_slot,
  input  spt_pkg::chain_t    chain_in,
  output spt_pkg::chain_t    chain_out,
  output spt_pkg::slot_t     slot,
  output spt_pkg::cell_stat_t stat
);

  spt_pkg::slot_t slot_r, slot_nxt;
  logic           occ;
  logic           is_match;

  assign occ      = cnt > CW'(IDX);
  assign is_match = occ && (slot_r.key == ctl.ins.key);

  assign chain_out.seen = chain_in.seen || is_match;
  assign chain_out.ge   = occ && (slot_r.level >= ctl.ins.level);

  assign stat.first = is_match && !chain_in.seen;
  assign stat.place = !chain_out.ge && chain_in.ge;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl.op)
      spt_pkg::CELL_DROP: begin
        if (chain_out.seen) begin
          slot_nxt = right_slot;
        end
      end
      spt_pkg::CELL_PLACE: begin
        if (!chain_out.ge) begin
          slot_nxt = chain_in.ge ? ctl.ins : left_slot;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

/* tb/tb_stable_priority_table_unit.sv */
`timescale 1ns / 100ps

module tb_stable_priority_table_unit;
  import spt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RAND_ITEMS = 1524;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    req_t             kind;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic [LVL_W-1:0] level;
  } table_req_t;

  typedef struct packed {
    status_t          status;
    logic [AGE_W-1:0] age;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] count;
  } table_reply_t;

  typedef struct {
    slot_t slot [DEPTH];
    int    fill;
  } table_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic clk;
  logic rst_n;

  spt_in_if  req_ch ();
  spt_out_if rsp_ch ();

  stable_priority_table_unit #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  table_req_t   pending_reqs [$];
  table_reply_t expected_replies [$];
  table_t       plan_tbl;
  table_t       live_tbl;
  logic [KEY_W-1:0] key_pool [8];

  int  queued_count;
  int  accepted_count;
  int  mism_count;
  bit  req_taken;
  bit  rsp_taken;
  bit  req_quiet;
  bit  rsp_quiet;
  int  req_gap;
  int  rsp_stall;
  table_req_t nxt_req;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int find_first(input table_t tbl, input logic [KEY_W-1:0] key);
    for (int i = 0; i < tbl.fill; i++) begin
      if (tbl.slot[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(inout table_t tbl, input int idx);
    for (int j = idx; j + 1 < tbl.fill; j++) tbl.slot[j] = tbl.slot[j + 1];
    tbl.fill--;
  endfunction

  // new entry goes behind every entry of equal or higher level
  function automatic int place_slot(inout table_t tbl, input slot_t ent);
    int p;
    p = 0;
    while (p < tbl.fill && tbl.slot[p].level >= ent.level) p++;
    for (int j = tbl.fill; j > p; j--) tbl.slot[j] = tbl.slot[j - 1];
    tbl.slot[p] = ent;
    tbl.fill++;
    return p;
  endfunction

  function automatic table_reply_t serve_request(inout table_t tbl, input table_req_t rq);
    table_reply_t rep;
    slot_t        hit_ent;
    int           idx;
    rep = '0;
    idx = find_first(tbl, rq.key);
    case (rq.kind)
      REQ_INSERT: begin
        if (tbl.fill >= DEPTH) begin
          rep.status = STS_FULL;
        end else begin
          idx = place_slot(tbl, slot_t'{rq.key, rq.age, rq.level});
          rep.age   = rq.age;
          rep.level = rq.level;
          rep.pos   = POS_W'(idx + 1);
        end
      end
      default: begin
        if (rq.kind == REQ_REMOVE && tbl.fill == 0) begin
          rep.status = STS_EMPTY;
        end else if (idx < 0) begin
          rep.status = STS_NOT_FOUND;
        end else begin
          hit_ent   = tbl.slot[idx];
          rep.age   = hit_ent.age;
          rep.level = hit_ent.level;
          rep.pos   = POS_W'(idx + 1);
          if (rq.kind == REQ_REMOVE) begin
            drop_slot(tbl, idx);
          end else if (rq.kind == REQ_CHANGE) begin
            // same-level change still moves the entry to the back of its level
            drop_slot(tbl, idx);
            hit_ent.level = rq.level;
            rep.level     = rq.level;
            rep.pos       = POS_W'(place_slot(tbl, hit_ent) + 1);
          end
        end
      end
    endcase
    rep.count = POS_W'(tbl.fill);
    return rep;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input table_t tbl);
    int r;
    r = $urandom_range(0, 99);
    if (tbl.fill > 0 && r < 70) return tbl.slot[$urandom_range(0, tbl.fill - 1)].key;
    if (r < 88) return key_pool[$urandom_range(0, 7)];
    return KEY_W'($urandom);
  endfunction

  function automatic req_t pick_kind(input mix_t mix);
    int roll;
    int ins_cut;
    int rem_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins_cut = 60;
        rem_cut = 70;
      end
      MIX_DRAIN: begin
        ins_cut = 15;
        rem_cut = 70;
      end
      default: begin
        ins_cut = 25;
        rem_cut = 50;
      end
    endcase
    if (roll < ins_cut) return REQ_INSERT;
    if (roll < rem_cut) return REQ_REMOVE;
    if (roll < 85) return REQ_SEARCH;
    return REQ_CHANGE;
  endfunction

  task automatic add_req(input req_t kind, input logic [KEY_W-1:0] key,
                         input logic [AGE_W-1:0] age, input logic [LVL_W-1:0] level);
    table_req_t rq;
    table_reply_t unused;
    rq = '{kind, key, age, level};
    unused = serve_request(plan_tbl, rq);
    pending_reqs.push_back(rq);
    queued_count++;
  endtask

  task automatic note_mismatch(input string what, input table_reply_t want,
                               input table_reply_t got);
    mism_count++;
    if (mism_count <= 10) begin
      $display("mismatch (%s): exp sts=%0d age=%0d lvl=%0d pos=%0d cnt=%0d",
               what, want.status, want.age, want.level, want.pos, want.count);
      $display("                 got sts=%0d age=%0d lvl=%0d pos=%0d cnt=%0d",
               got.status, got.age, got.level, got.pos, got.count);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (req_taken || !req_ch.valid)) begin
      if (req_gap > 0) begin
        req_ch.valid <= 1'b0;
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        nxt_req = pending_reqs.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= nxt_req.kind;
        req_ch.cust_key   <= nxt_req.key;
        req_ch.cust_age   <= nxt_req.age;
        req_ch.prio_level <= nxt_req.level;
        req_gap = req_quiet ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_taken) begin
        rsp_stall = rsp_quiet ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
      end
      if (rsp_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    table_req_t   acc;
    table_reply_t got;
    table_reply_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        acc = '{req_t'(req_ch.req_type), req_ch.cust_key, req_ch.cust_age,
                req_ch.prio_level};
        expected_replies.push_back(serve_request(live_tbl, acc));
        accepted_count++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{status_t'(rsp_ch.status), rsp_ch.found_age, rsp_ch.found_level,
                rsp_ch.found_pos, rsp_ch.entry_count};
        if (expected_replies.size() == 0) begin
          note_mismatch("no result pending", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) note_mismatch("wrong field", want, got);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    mix_t mix;
    int   seg_len;
    req_t kind;
    logic [KEY_W-1:0] key;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.cust_key = '0;
    req_ch.cust_age = '0;
    req_ch.prio_level = '0;
    rsp_ch.ready = 1'b0;
    plan_tbl.fill = 0;
    live_tbl.fill = 0;
    queued_count = 0;
    accepted_count = 0;
    mism_count = 0;
    req_gap = 0;
    rsp_stall = 0;
    req_quiet = 1'b0;
    rsp_quiet = 1'b0;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;

    // empty table
    add_req(REQ_REMOVE, 16'h0000, 7'd0, 4'd0);
    add_req(REQ_SEARCH, 16'hFFFF, 7'd127, 4'd15);
    add_req(REQ_CHANGE, 16'h0000, 7'd0, 4'd15);
    // ties, duplicates, same-level change, missing keys
    add_req(REQ_INSERT, 16'hFFFF, 7'd127, 4'd15);
    add_req(REQ_INSERT, 16'h0000, 7'd0, 4'd0);
    add_req(REQ_INSERT, 16'h1234, 7'd5, 4'd15);
    add_req(REQ_INSERT, 16'h1234, 7'd9, 4'd7);
    add_req(REQ_SEARCH, 16'h1234, 7'd0, 4'd0);
    add_req(REQ_CHANGE, 16'hFFFF, 7'd3, 4'd15);
    add_req(REQ_CHANGE, 16'hBEEF, 7'd0, 4'd1);
    add_req(REQ_REMOVE, 16'hBEEF, 7'd0, 4'd0);
    // fill up, then full table
    for (int i = 0; i < DEPTH - 4; i++) begin
      add_req(REQ_INSERT, KEY_W'(16'h0100 + i), AGE_W'(i * 11), LVL_W'(i * 5));
    end
    add_req(REQ_INSERT, 16'hAAAA, 7'd127, 4'd15);
    add_req(REQ_CHANGE, 16'h0000, 7'd1, 4'd15);
    add_req(REQ_REMOVE, 16'h1234, 7'd0, 4'd0);

    while (queued_count < RAND_ITEMS + 26) begin
      mix = mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(30, 90);
      for (int k = 0; k < seg_len; k++) begin
        kind = pick_kind(mix);
        if (kind == REQ_INSERT && $urandom_range(0, 3) != 0) begin
          key = KEY_W'($urandom);
        end else begin
          key = pick_key(plan_tbl);
        end
        add_req(kind, key, AGE_W'($urandom_range(0, 127)), LVL_W'($urandom_range(0, 15)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(accepted_count == queued_count && expected_replies.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mism_count == 0 && expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/spt_pkg.sv
src/spt_if.sv
src/spt_cell.sv
src/stable_priority_table_unit.sv
tb/tb_stable_priority_table_unit.sv
